// ===== src/crt_pkg.sv =====
package crt_pkg;

  localparam int unsigned MaskW  = 32;
  localparam int unsigned TotalW = 8;

  typedef enum logic [2:0] {
    STAT_ACCEPTED   = 3'd0,
    STAT_BAD_HEADER = 3'd1,
    STAT_NO_SLOT    = 3'd2,
    STAT_RELEASED   = 3'd3,
    STAT_BAD_SLOT   = 3'd4
  } crt_status_e;

  typedef enum logic {
    OP_RECEIVE = 1'b0,
    OP_RELEASE = 1'b1
  } crt_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_SELECT,
    ST_UPDATE
  } crt_state_e;

  typedef struct packed {
    crt_op_e             op;
    logic [31:0]         flow_id;
    logic [31:0]         frame_num;
    logic [TotalW-1:0]   chunk_total;
    logic [TotalW-1:0]   chunk_index;
    logic [4:0]          slot_select;
  } crt_req_t;

  typedef struct packed {
    crt_status_e         status;
    logic [3:0]          slot_index;
    logic                frame_complete;
    logic [MaskW-1:0]    chunk_bits;
    logic [5:0]          expected_chunks;
    logic [4:0]          slots_in_use;
  } crt_rsp_t;

  // Step commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic select;
    logic update;
  } crt_cmd_t;

endpackage

// ===== src/chunk_reassembly_tracker.sv =====
// Channel   Handshake               Payload
// request   start & !busy           req_i  (crt_req_t)
// result    rsp_valid_o, one cycle  rsp_o  (crt_rsp_t)
//
// Each request runs capture, parallel tag compare over all slots, lowest-slot
// select and table update in turn; the result strobes the cycle after the update.
// busy is high through the compare, select and update states; the next request
// may start in the cycle the result is shown. The receiver cannot stall results.
// Reset clears all slot valid bits and the occupancy count at once.
module chunk_reassembly_tracker
  import crt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned MAX_CHUNKS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  crt_req_t req_i,
  output logic     rsp_valid_o,
  output crt_rsp_t rsp_o
);

  crt_cmd_t cmd;

  crt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  crt_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== src/crt_ctrl.sv =====
module crt_ctrl
  import crt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output crt_cmd_t cmd_o
);

  crt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_COMPARE;
        end
      end
      ST_COMPARE: state_d = ST_SELECT;
      ST_SELECT:  state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_COMPARE: cmd_o.compare = 1'b1;
      ST_SELECT:  cmd_o.select  = 1'b1;
      ST_UPDATE:  cmd_o.update  = 1'b1;
      default:    busy = 1'b0;
    endcase
  end

endmodule

// ===== src/crt_datapath.sv =====
module crt_datapath
  import crt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned MAX_CHUNKS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  crt_cmd_t cmd_i,
  input  crt_req_t req_i,
  output logic     rsp_valid_o,
  output crt_rsp_t rsp_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  // Slot table
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]          stream_q [NUM_SLOTS];
  logic [31:0]          frame_q  [NUM_SLOTS];
  logic [5:0]           count_q  [NUM_SLOTS];
  logic [MaskW-1:0]     mask_q   [NUM_SLOTS];
  logic [CW-1:0]        used_q, used_d;

  // Per-request working registers
  crt_req_t             req_q;
  logic [NUM_SLOTS-1:0] match_q, free_q;
  logic [IW-1:0]        hit_q;
  logic                 found_q, opened_q;

  logic                 rsp_valid_q;
  crt_rsp_t             rsp_q, rsp_d;

  logic                 wr_open, wr_mask;
  logic [MaskW-1:0]     new_mask;

  function automatic logic [IW-1:0] lowest(input logic [NUM_SLOTS-1:0] v);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = IW'(i);
    end
    return idx;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.compare) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        match_q[i] <= valid_q[i] && (stream_q[i] == req_q.flow_id)
                      && (frame_q[i] == req_q.frame_num);
      end
      free_q <= ~valid_q;
    end
    if (cmd_i.select) begin
      // Prefer a matching slot, else open the lowest free one
      found_q  <= (|match_q) || (|free_q);
      opened_q <= ~(|match_q);
      hit_q    <= (|match_q) ? lowest(match_q) : lowest(free_q);
    end
    if (wr_open) begin
      stream_q[hit_q] <= req_q.flow_id;
      frame_q[hit_q]  <= req_q.frame_num;
      count_q[hit_q]  <= req_q.chunk_total[5:0];
    end
    if (wr_mask) begin
      mask_q[hit_q] <= new_mask;
    end
    if (cmd_i.update) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      used_q      <= used_d;
      rsp_valid_q <= cmd_i.update;
    end
  end

  always_comb begin
    logic             bad_hdr, bad_sel;
    logic [MaskW-1:0] base, full, chunk_bit;
    logic [IW-1:0]    sel;

    bad_hdr = (req_q.chunk_total == '0)
              || (req_q.chunk_total > TotalW'(MAX_CHUNKS))
              || (req_q.chunk_index >= req_q.chunk_total);
    bad_sel = (6'(req_q.slot_select) >= 6'(NUM_SLOTS));
    sel     = req_q.slot_select[IW-1:0];

    base      = opened_q ? '0 : mask_q[hit_q];
    chunk_bit = MaskW'(1) << req_q.chunk_index[4:0];
    new_mask  = base | chunk_bit;
    full      = (req_q.chunk_total >= TotalW'(MaskW)) ? '1
              : ~({MaskW{1'b1}} << req_q.chunk_total);

    valid_d = valid_q;
    used_d  = used_q;
    wr_open = 1'b0;
    wr_mask = 1'b0;

    rsp_d        = '0;
    rsp_d.status = STAT_ACCEPTED;

    if (cmd_i.update) begin
      if (req_q.op == OP_RELEASE) begin
        if (bad_sel) begin
          rsp_d.status = STAT_BAD_SLOT;
        end else begin
          rsp_d.status     = STAT_RELEASED;
          rsp_d.slot_index = req_q.slot_select[3:0];
          valid_d[sel]     = 1'b0;
          if (valid_q[sel]) begin
            used_d = used_q - CW'(1);
          end
        end
      end else if (bad_hdr) begin
        rsp_d.status = STAT_BAD_HEADER;
      end else if (!found_q) begin
        rsp_d.status = STAT_NO_SLOT;
      end else begin
        wr_mask = 1'b1;
        if (opened_q) begin
          wr_open        = 1'b1;
          valid_d[hit_q] = 1'b1;
          used_d         = used_q + CW'(1);
        end
        rsp_d.slot_index      = 4'(hit_q);
        rsp_d.frame_complete  = (new_mask == full);
        rsp_d.chunk_bits      = new_mask;
        rsp_d.expected_chunks = opened_q ? req_q.chunk_total[5:0] : count_q[hit_q];
      end
    end
    rsp_d.slots_in_use = 5'(used_d);
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/crt_checker.sv =====
module crt_checker
  import crt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     rsp_valid_o,
  input crt_rsp_t rsp_o
);

  // An accepted request holds off the next one
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 rsp_valid_o)
    else $error("result missing four cycles after request");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == STAT_BAD_HEADER || rsp_o.status == STAT_NO_SLOT
                     || rsp_o.status == STAT_BAD_SLOT))
    |-> (rsp_o.chunk_bits == '0 && !rsp_o.frame_complete && rsp_o.slot_index == '0))
    else $error("rejected request carries slot data");

endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
